FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and types of the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int POOL_BLOCKS = 1024;
	localparam int WORD_BITS  = 64;
	localparam int MAP_WORDS  = (POOL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BLK_W      = $clog2(POOL_BLOCKS);
	localparam int LIM_W      = BLK_W + 1;
	localparam int ROW_W      = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int CHUNK_BITS = 8;
	localparam int CHK_W      = $clog2(CHUNK_BITS);
	localparam int CHUNKS     = WORD_BITS / CHUNK_BITS;
	localparam int CHUNK_W    = $clog2(CHUNKS);

	localparam int BYTES_W    = 24;
	localparam int ADDR_W     = 32;
	localparam int SHIFT_W    = 4;
	localparam int MANAGED_W  = 11;
	localparam int NEED_W     = BYTES_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	localparam logic [SHIFT_W-1:0]   RST_BLOCK_SHIFT    = SHIFT_W'(6);
	localparam logic [MANAGED_W-1:0] RST_BLOCKS_MANAGED = MANAGED_W'(1024);
	localparam logic [ADDR_W-1:0]    RST_POOL_BASE      = '0;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_NOT_HEAD = 2'd2
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SHIFT    = 2'd0,
		REG_BLOCKS_MANAGED = 2'd1,
		REG_POOL_BASE      = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_RD,
		ST_SCAN,
		ST_MARK_PREP,
		ST_MRD,
		ST_MWR,
		ST_FRD,
		ST_FLOAD,
		ST_FWALK,
		ST_FWR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [SHIFT_W-1:0]   block_shift;
		logic [MANAGED_W-1:0] blocks_managed;
		logic [ADDR_W-1:0]    pool_base;
	} cfg_t;

	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [ROW_W-1:0]     addr;
		logic [WORD_BITS-1:0] used;
		logic [WORD_BITS-1:0] head;
	} ram_req_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] used;
		logic [WORD_BITS-1:0] head;
	} ram_rsp_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [ADDR_W-1:0] grant;
		logic [BLK_W-1:0]  first;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/ffba_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_map_ram
// Used and head bitmap rows, one port, registered read, per-row valid bits
// so that rows never written since reset read as zero.
// ----------------------------------------------------------------------------
module ffba_map_ram (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ffba_pkg::ram_req_t req,
	output ffba_pkg::ram_rsp_t      rsp
);

	logic [ffba_pkg::WORD_BITS-1:0] used_mem [ffba_pkg::MAP_WORDS];
	logic [ffba_pkg::WORD_BITS-1:0] head_mem [ffba_pkg::MAP_WORDS];
	logic [ffba_pkg::MAP_WORDS-1:0] row_valid_q;
	logic [ffba_pkg::WORD_BITS-1:0] used_rd_q;
	logic [ffba_pkg::WORD_BITS-1:0] head_rd_q;
	logic                           rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			used_mem[req.addr] <= req.used;
			head_mem[req.addr] <= req.head;
		end
		if (req.rd_en) begin
			used_rd_q <= used_mem[req.addr];
			head_rd_q <= head_mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= row_valid_q[req.addr];
			end
		end
	end

	assign rsp.used = rd_valid_q ? used_rd_q : '0;
	assign rsp.head = rd_valid_q ? head_rd_q : '0;

endmodule
`default_nettype wire

FILE: rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer and chunk logic: first-fit scan and free walk over the bitmap rows,
// eight bits per cycle between row reads, and row marking a whole row per write.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ffba_pkg::cfg_t                    cfg,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire ffba_pkg::cmd_t                    in_cmd,
	input  wire logic [ffba_pkg::BYTES_W-1:0]      in_bytes,
	input  wire logic [ffba_pkg::ADDR_W-1:0]       in_addr,
	input  wire logic                              out_free,
	output ffba_pkg::result_t                      res,
	output ffba_pkg::ram_req_t                     ram_req,
	input  wire ffba_pkg::ram_rsp_t                ram_rsp
);

	localparam logic [ffba_pkg::CHUNK_W-1:0] LAST_CHUNK = ffba_pkg::CHUNK_W'(ffba_pkg::CHUNKS - 1);
	localparam logic [ffba_pkg::ROW_W-1:0]   LAST_ROW   = ffba_pkg::ROW_W'(ffba_pkg::MAP_WORDS - 1);

	ffba_pkg::state_t state_q, state_d;
	ffba_pkg::cmd_t   cmd_q;
	ffba_pkg::status_t status_q;

	logic [ffba_pkg::BYTES_W-1:0]   bytes_q;
	logic [ffba_pkg::ADDR_W-1:0]    diff_q;
	logic [ffba_pkg::NEED_W-1:0]    need_q;
	logic [ffba_pkg::BLK_W-1:0]     idx_q;
	logic [ffba_pkg::ROW_W-1:0]     w_q;
	logic [ffba_pkg::CHUNK_W-1:0]   c_q;
	logic [ffba_pkg::LIM_W-1:0]     run_q;
	logic [ffba_pkg::BLK_W-1:0]     end_q;
	logic [ffba_pkg::BLK_W-1:0]     start_q;
	logic [ffba_pkg::WORD_BITS-1:0] used_w_q;
	logic [ffba_pkg::WORD_BITS-1:0] head_w_q;
	logic                           go_q;
	logic                           chk_q;
	logic [ffba_pkg::ADDR_W-1:0]    grant_q;
	logic [ffba_pkg::BLK_W-1:0]     first_q;

	// managed limit
	logic [ffba_pkg::LIM_W-1:0] limit;
	assign limit = (cfg.blocks_managed > ffba_pkg::MANAGED_W'(ffba_pkg::POOL_BLOCKS))
		? ffba_pkg::LIM_W'(ffba_pkg::POOL_BLOCKS) : cfg.blocks_managed[ffba_pkg::LIM_W-1:0];

	// block count and free index
	logic [ffba_pkg::BYTES_W-1:0] n_quot;
	logic                         n_rem;
	logic [ffba_pkg::NEED_W-1:0]  n_need;
	logic [ffba_pkg::ADDR_W-1:0]  f_idx;
	logic                         f_in;

	assign n_quot = bytes_q >> cfg.block_shift;
	assign n_rem  = |(bytes_q & ((ffba_pkg::BYTES_W'(1) << cfg.block_shift)
		- ffba_pkg::BYTES_W'(1)));
	assign n_need = ffba_pkg::NEED_W'(n_quot) + ffba_pkg::NEED_W'(n_rem);
	assign f_idx  = diff_q >> cfg.block_shift;
	assign f_in   = f_idx < ffba_pkg::ADDR_W'(limit);

	// chunk position
	logic [ffba_pkg::BLK_W-1:0] s_base;
	logic [ffba_pkg::LIM_W-1:0] s_next;
	assign s_base = {w_q, c_q, ffba_pkg::CHK_W'(0)};
	assign s_next = ffba_pkg::LIM_W'(s_base) + ffba_pkg::LIM_W'(ffba_pkg::CHUNK_BITS);

	// first-fit scan of one chunk
	logic [ffba_pkg::CHUNK_BITS-1:0] s_chunk;
	logic [ffba_pkg::LIM_W-1:0]      s_run;
	logic [ffba_pkg::LIM_W-1:0]      s_gi;
	logic                            s_found;
	logic [ffba_pkg::BLK_W-1:0]      s_end;

	always_comb begin
		s_chunk = ram_rsp.used[c_q * ffba_pkg::CHUNK_BITS +: ffba_pkg::CHUNK_BITS];
		s_run   = run_q;
		s_found = 1'b0;
		s_end   = '0;
		s_gi    = '0;
		for (int j = 0; j < ffba_pkg::CHUNK_BITS; j++) begin
			s_gi = ffba_pkg::LIM_W'(s_base) + ffba_pkg::LIM_W'(j);
			if (!s_found && (s_gi < limit)) begin
				if (!s_chunk[j]) begin
					s_run = s_run + ffba_pkg::LIM_W'(1);
					if (ffba_pkg::NEED_W'(s_run) == need_q) begin
						s_found = 1'b1;
						s_end   = s_gi[ffba_pkg::BLK_W-1:0];
					end
				end else begin
					s_run = '0;
				end
			end
		end
	end

	// free walk over one chunk
	logic [ffba_pkg::CHUNK_BITS-1:0] w_chunk_u;
	logic [ffba_pkg::CHUNK_BITS-1:0] w_chunk_h;
	logic [ffba_pkg::CHUNK_BITS-1:0] w_chunk_n;
	logic [ffba_pkg::LIM_W-1:0]      w_gi;
	logic                            w_go;

	always_comb begin
		w_chunk_u = used_w_q[c_q * ffba_pkg::CHUNK_BITS +: ffba_pkg::CHUNK_BITS];
		w_chunk_h = head_w_q[c_q * ffba_pkg::CHUNK_BITS +: ffba_pkg::CHUNK_BITS];
		w_chunk_n = w_chunk_u;
		w_go      = go_q;
		w_gi      = '0;
		for (int j = 0; j < ffba_pkg::CHUNK_BITS; j++) begin
			w_gi = ffba_pkg::LIM_W'(s_base) + ffba_pkg::LIM_W'(j);
			if (w_gi >= ffba_pkg::LIM_W'(idx_q)) begin
				if (w_go && (w_gi < limit) && w_chunk_u[j] && !w_chunk_h[j]) begin
					w_chunk_n[j] = 1'b0;
				end else begin
					w_go = 1'b0;
				end
			end
		end
	end

	// row masks for marking a granted run
	logic [ffba_pkg::WORD_BITS-1:0] m_mask;
	logic [ffba_pkg::WORD_BITS-1:0] m_head;
	logic [ffba_pkg::BLK_W-1:0]     m_gi;
	logic [ffba_pkg::BLK_W-1:0]     mp_start;
	logic [ffba_pkg::ADDR_W-1:0]    g_addr;

	always_comb begin
		m_mask = '0;
		m_head = '0;
		m_gi   = '0;
		for (int p = 0; p < ffba_pkg::WORD_BITS; p++) begin
			m_gi      = {w_q, ffba_pkg::BIT_W'(p)};
			m_mask[p] = (m_gi >= start_q) && (m_gi <= end_q);
			m_head[p] = (m_gi == start_q);
		end
	end

	assign mp_start = ffba_pkg::BLK_W'(ffba_pkg::LIM_W'(end_q) + ffba_pkg::LIM_W'(1)
		- need_q[ffba_pkg::LIM_W-1:0]);
	assign g_addr = cfg.pool_base + (ffba_pkg::ADDR_W'(start_q) << cfg.block_shift);

	logic hb;
	assign hb = ram_rsp.head[idx_q[ffba_pkg::BIT_W-1:0]];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				if (in_valid) state_d = ffba_pkg::ST_PREP;
			end
			ffba_pkg::ST_PREP: begin
				if (cmd_q == ffba_pkg::CMD_ALLOC) begin
					state_d = (n_need == '0) ? ffba_pkg::ST_DONE : ffba_pkg::ST_RD;
				end else begin
					state_d = f_in ? ffba_pkg::ST_FRD : ffba_pkg::ST_DONE;
				end
			end
			ffba_pkg::ST_RD: state_d = ffba_pkg::ST_SCAN;
			ffba_pkg::ST_SCAN: begin
				if (s_found) state_d = ffba_pkg::ST_MARK_PREP;
				else if (s_next >= limit) state_d = ffba_pkg::ST_DONE;
				else if (c_q == LAST_CHUNK) state_d = ffba_pkg::ST_RD;
			end
			ffba_pkg::ST_MARK_PREP: state_d = ffba_pkg::ST_MRD;
			ffba_pkg::ST_MRD: state_d = ffba_pkg::ST_MWR;
			ffba_pkg::ST_MWR: begin
				state_d = (w_q == end_q[ffba_pkg::BLK_W-1:ffba_pkg::BIT_W])
					? ffba_pkg::ST_DONE : ffba_pkg::ST_MRD;
			end
			ffba_pkg::ST_FRD: state_d = ffba_pkg::ST_FLOAD;
			ffba_pkg::ST_FLOAD: begin
				state_d = (chk_q && !hb) ? ffba_pkg::ST_DONE : ffba_pkg::ST_FWALK;
			end
			ffba_pkg::ST_FWALK: begin
				if (!w_go || (c_q == LAST_CHUNK)) state_d = ffba_pkg::ST_FWR;
			end
			ffba_pkg::ST_FWR: begin
				state_d = (go_q && (w_q != LAST_ROW)) ? ffba_pkg::ST_FRD : ffba_pkg::ST_DONE;
			end
			ffba_pkg::ST_DONE: begin
				if (out_free) state_d = ffba_pkg::ST_IDLE;
			end
			default: state_d = ffba_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		ram_req.rd_en = 1'b0;
		ram_req.wr_en = 1'b0;
		ram_req.addr  = w_q;
		ram_req.used  = used_w_q;
		ram_req.head  = head_w_q;
		res.valid     = 1'b0;
		res.status    = status_q;
		res.grant     = grant_q;
		res.first     = first_q;
		case (state_q)
			ffba_pkg::ST_IDLE: in_ready = 1'b1;
			ffba_pkg::ST_RD, ffba_pkg::ST_MRD, ffba_pkg::ST_FRD: ram_req.rd_en = 1'b1;
			ffba_pkg::ST_MWR: begin
				ram_req.wr_en = 1'b1;
				ram_req.used  = ram_rsp.used | m_mask;
				ram_req.head  = ram_rsp.head | m_head;
			end
			ffba_pkg::ST_FWR: ram_req.wr_en = 1'b1;
			ffba_pkg::ST_DONE: res.valid = out_free;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_IDLE;
			go_q    <= 1'b0;
			chk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ffba_pkg::ST_PREP: begin
					go_q  <= 1'b1;
					chk_q <= 1'b1;
				end
				ffba_pkg::ST_FLOAD: chk_q <= 1'b0;
				ffba_pkg::ST_FWALK: go_q <= w_go;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				cmd_q   <= in_cmd;
				bytes_q <= in_bytes;
				diff_q  <= in_addr - cfg.pool_base;
				run_q   <= '0;
				c_q     <= '0;
			end
			ffba_pkg::ST_PREP: begin
				need_q <= n_need;
				idx_q  <= f_idx[ffba_pkg::BLK_W-1:0];
				w_q    <= (cmd_q == ffba_pkg::CMD_ALLOC)
					? '0 : f_idx[ffba_pkg::BLK_W-1:ffba_pkg::BIT_W];
				grant_q <= '0;
				first_q <= '0;
				status_q <= (cmd_q == ffba_pkg::CMD_ALLOC)
					? ffba_pkg::STAT_NO_SPACE : ffba_pkg::STAT_NOT_HEAD;
			end
			ffba_pkg::ST_SCAN: begin
				run_q <= s_run;
				end_q <= s_end;
				if (c_q == LAST_CHUNK) begin
					w_q <= w_q + ffba_pkg::ROW_W'(1);
				end
				c_q <= c_q + ffba_pkg::CHUNK_W'(1);
			end
			ffba_pkg::ST_MARK_PREP: begin
				start_q <= mp_start;
				w_q     <= mp_start[ffba_pkg::BLK_W-1:ffba_pkg::BIT_W];
			end
			ffba_pkg::ST_MWR: begin
				w_q <= w_q + ffba_pkg::ROW_W'(1);
				if (w_q == end_q[ffba_pkg::BLK_W-1:ffba_pkg::BIT_W]) begin
					status_q <= ffba_pkg::STAT_OK;
					grant_q  <= g_addr;
					first_q  <= start_q;
				end
			end
			ffba_pkg::ST_FLOAD: begin
				used_w_q <= ram_rsp.used;
				head_w_q <= chk_q
					? (ram_rsp.head & ~(ffba_pkg::WORD_BITS'(1)
						<< idx_q[ffba_pkg::BIT_W-1:0]))
					: ram_rsp.head;
				c_q      <= chk_q ? idx_q[ffba_pkg::BIT_W-1:ffba_pkg::CHK_W] : '0;
			end
			ffba_pkg::ST_FWALK: begin
				used_w_q[c_q * ffba_pkg::CHUNK_BITS +: ffba_pkg::CHUNK_BITS] <= w_chunk_n;
				c_q <= c_q + ffba_pkg::CHUNK_W'(1);
			end
			ffba_pkg::ST_FWR: begin
				w_q      <= w_q + ffba_pkg::ROW_W'(1);
				status_q <= ffba_pkg::STAT_OK;
				first_q  <= idx_q;
			end
			default: ;
		endcase
	end

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.rd_en && ram_req.wr_en))
		else $error("bitmap row read and written in one cycle");

	a_accept_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ffba_pkg::ST_PREP))
		else $error("accepted request did not enter prep");

	a_result_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ffba_pkg::ST_DONE) && out_free)
		else $error("result issued outside done");

	a_scan_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_SCAN) |->
		($past(state_q) == ffba_pkg::ST_RD) || ($past(state_q) == ffba_pkg::ST_SCAN))
		else $error("scan without a row read");

	a_mark_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_MWR) |-> ($past(state_q) == ffba_pkg::ST_MRD))
		else $error("mark write without a row read");

endmodule
`default_nettype wire

FILE: rtl/first_fit_bitmap_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Allocate: a row read, then a scan of the row eight blocks per cycle in the chunk
// unit, row after row; a found run is then marked with a read and a write per row.
// Free: each row is read, loaded, walked chunk by chunk and written back; the walk
// ends early when the released block is not a head.
// One request at a time; the next request is taken while the result waits.
// Reset clears both bitmaps at once through per-row valid bits, no clearing pass,
// and loads block_shift 6, blocks_managed 1024 and pool_base 0.
// ----------------------------------------------------------------------------
// first_fit_bitmap_block_allocator
// Block pool allocator with first-fit search over used and head bitmaps.
// ----------------------------------------------------------------------------
module first_fit_bitmap_block_allocator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [ffba_pkg::IN_DATA_W-1:0]      s_tdata,  // request_bytes, release_address
	input  wire logic [0:0]                          s_tuser,  // cmd
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [ffba_pkg::OUT_DATA_W-1:0]          m_tdata,  // grant_address, first_block
	output logic [1:0]                               m_tuser,  // status
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ffba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ffba_pkg::cfg_t     cfg_q;
	ffba_pkg::result_t  res;
	ffba_pkg::ram_req_t ram_req;
	ffba_pkg::ram_rsp_t ram_rsp;
	ffba_pkg::status_t  out_status_q;

	logic                          out_valid_q;
	logic [ffba_pkg::ADDR_W-1:0]   out_grant_q;
	logic [ffba_pkg::BLK_W-1:0]    out_first_q;
	logic                          out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_shift    <= ffba_pkg::RST_BLOCK_SHIFT;
			cfg_q.blocks_managed <= ffba_pkg::RST_BLOCKS_MANAGED;
			cfg_q.pool_base      <= ffba_pkg::RST_POOL_BASE;
		end else if (cfg_valid) begin
			case (cfg_index)
				ffba_pkg::REG_BLOCK_SHIFT:
					cfg_q.block_shift <= cfg_data[ffba_pkg::SHIFT_W-1:0];
				ffba_pkg::REG_BLOCKS_MANAGED:
					cfg_q.blocks_managed <= cfg_data[ffba_pkg::MANAGED_W-1:0];
				ffba_pkg::REG_POOL_BASE:
					cfg_q.pool_base <= cfg_data[ffba_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	ffba_map_ram u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rsp    (ram_rsp)
	);

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (ffba_pkg::cmd_t'(s_tuser[0])),
		.in_bytes (s_tdata[ffba_pkg::BYTES_W-1:0]),
		.in_addr  (s_tdata[ffba_pkg::BYTES_W +: ffba_pkg::ADDR_W]),
		.out_free (out_free),
		.res      (res),
		.ram_req  (ram_req),
		.ram_rsp  (ram_rsp)
	);

	// output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_status_q <= res.status;
			out_grant_q  <= res.grant;
			out_first_q  <= res.first;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(ffba_pkg::OUT_DATA_W - ffba_pkg::ADDR_W - ffba_pkg::BLK_W){1'b0}},
		out_first_q, out_grant_q};

endmodule
`default_nettype wire
